### rtl/bqsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsc_pkg
// Shared types and constants of the bi-quadratic spline correlation core.
// ----------------------------------------------------------------------------
package bqsc_pkg;

	// defaults of the top level parameters
	localparam int MAX_DIMS_DEF   = 6;
	localparam int COORD_BITS_DEF = 16;

	// port and register widths
	localparam int NUM_PORTS  = 6;
	localparam int DIMS_BITS  = 3;
	localparam int SCALE_BITS = 16;
	localparam int SCALE_FRAC = 11;
	localparam int OUT_BITS   = 17;
	localparam int CFG_IDX_BITS = 3;

	// working format: Q0.30 powers, factors up to 1.0 need one more bit
	localparam int WORK_FRAC = 30;
	localparam int FAC_BITS  = WORK_FRAC + 1;
	localparam logic [FAC_BITS-1:0] ONE_W = FAC_BITS'(1) << WORK_FRAC;

	// spline coefficients: low branch 1 - 15 s^2 + 35 s^3 - 195/8 s^4, high 5/3 t^4
	localparam int LOW_C2 = 15;
	localparam int LOW_C3 = 35;
	localparam int LOW_C4 = 195;
	localparam int LOW_C4_SHIFT = 3;
	localparam int HIGH_C4 = 5;

	// floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for x below 2^31
	localparam int RECIP3_SHIFT = 33;
	localparam logic [31:0] RECIP3 = 32'd2863311531;

	// result rounding from Q0.30 to Q1.16
	localparam int OUT_FRAC = 16;
	localparam logic [OUT_BITS-1:0] OUT_ONE = OUT_BITS'(1) << OUT_FRAC;

	// pipeline depth of one dimension lane
	localparam int LANE_STAGES = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ACTIVE_DIMS = 3'd0,
		REG_SCALE_0     = 3'd1,
		REG_SCALE_1     = 3'd2,
		REG_SCALE_2     = 3'd3,
		REG_SCALE_3     = 3'd4,
		REG_SCALE_4     = 3'd5,
		REG_SCALE_5     = 3'd6
	} cfg_reg_t;

endpackage

### rtl/bqsc_factor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqsc_factor
// One dimension lane: distance, scaling, range test, power chain and spline
// factor in Q1.30, eight register stages.
// ----------------------------------------------------------------------------
module bqsc_factor #(
	parameter int COORD_BITS = bqsc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic [bqsc_pkg::LANE_STAGES-1:0]    adv,
	input  logic [COORD_BITS-1:0]               a,
	input  logic [COORD_BITS-1:0]               b,
	input  logic [bqsc_pkg::SCALE_BITS-1:0]     scale,
	input  logic                                active,
	output logic [bqsc_pkg::FAC_BITS-1:0]       factor
);

	localparam int WF = bqsc_pkg::WORK_FRAC;
	localparam int FB = bqsc_pkg::FAC_BITS;
	localparam int PF = COORD_BITS + bqsc_pkg::SCALE_FRAC;
	localparam int PB = COORD_BITS + bqsc_pkg::SCALE_BITS;
	localparam int LB = 38;

	logic [COORD_BITS-1:0] d_s1;
	logic [PB-1:0]         prod_s2;
	logic [WF-1:0]         base_s3, base_s4, base_s5;
	logic                  zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic                  low_s3, low_s4, low_s5, low_s6, low_s7;
	logic [WF-1:0]         p2_s4, p2_s5, p2_s6;
	logic [WF-1:0]         p3_s5, p3_s6;
	logic [WF-1:0]         p4_s6;
	logic [FB-1:0]         lowf_s7;
	logic [62:0]           hq_s7;
	logic [FB-1:0]         factor_s8;

	logic [WF-1:0]  s_w;
	logic [PB+2:0]  prod5;
	logic           zero_w, low_w;
	logic [FB-1:0]  t_w;
	logic [2*WF-1:0] sq, cu, qu;
	logic [LB-1:0]  pos, neg, diff;
	logic [FB-1:0]  lowf_w;
	logic [30:0]    x5;
	logic [WF-1:0]  q3;
	logic [FB-1:0]  highf_w;

	// scaled distance truncated to Q0.30
	if (PF >= WF) begin : g_s_down
		assign s_w = prod_s2[PF-1 -: WF];
	end else begin : g_s_up
		assign s_w = {prod_s2[PF-1:0], {(WF-PF){1'b0}}};
	end

	assign zero_w = |prod_s2[PB-1:PF];
	assign prod5  = (PB+3)'(prod_s2) * (PB+3)'(5);
	assign low_w  = prod5 < ((PB+3)'(2) << PF);
	assign t_w    = bqsc_pkg::ONE_W - FB'(s_w);

	assign sq = base_s3 * base_s3;
	assign cu = p2_s4 * base_s4;
	assign qu = p3_s5 * base_s5;

	always_comb begin
		pos = LB'(bqsc_pkg::ONE_W) + LB'(p3_s6) * LB'(bqsc_pkg::LOW_C3);
		neg = LB'(p2_s6) * LB'(bqsc_pkg::LOW_C2)
			+ ((LB'(p4_s6) * LB'(bqsc_pkg::LOW_C4)) >> bqsc_pkg::LOW_C4_SHIFT);
		diff = pos - neg;
		if (pos < neg) begin
			lowf_w = '0;
		end else if (diff > LB'(bqsc_pkg::ONE_W)) begin
			lowf_w = bqsc_pkg::ONE_W;
		end else begin
			lowf_w = diff[FB-1:0];
		end
	end

	// t stays at or below 0.6 in the high branch, so 5*t^4 is below 2^30
	assign x5 = 31'(p4_s6) * 31'(bqsc_pkg::HIGH_C4);
	assign q3 = hq_s7[62:bqsc_pkg::RECIP3_SHIFT];
	assign highf_w = (FB'(q3) > bqsc_pkg::ONE_W) ? bqsc_pkg::ONE_W : FB'(q3);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			d_s1 <= (a >= b) ? (a - b) : (b - a);
		end
		if (adv[1]) begin
			prod_s2 <= PB'(d_s1) * PB'(scale);
		end
		if (adv[2]) begin
			base_s3 <= low_w ? s_w : t_w[WF-1:0];
			zero_s3 <= zero_w;
			low_s3  <= low_w;
		end
		if (adv[3]) begin
			p2_s4   <= sq[2*WF-1:WF];
			base_s4 <= base_s3;
			zero_s4 <= zero_s3;
			low_s4  <= low_s3;
		end
		if (adv[4]) begin
			p3_s5   <= cu[2*WF-1:WF];
			p2_s5   <= p2_s4;
			base_s5 <= base_s4;
			zero_s5 <= zero_s4;
			low_s5  <= low_s4;
		end
		if (adv[5]) begin
			p4_s6   <= qu[2*WF-1:WF];
			p3_s6   <= p3_s5;
			p2_s6   <= p2_s5;
			zero_s6 <= zero_s5;
			low_s6  <= low_s5;
		end
		if (adv[6]) begin
			lowf_s7 <= lowf_w;
			hq_s7   <= 63'(x5) * 63'(bqsc_pkg::RECIP3);
			zero_s7 <= zero_s6;
			low_s7  <= low_s6;
		end
		if (adv[7]) begin
			if (!active) begin
				factor_s8 <= bqsc_pkg::ONE_W;
			end else if (zero_s7) begin
				factor_s8 <= '0;
			end else if (low_s7) begin
				factor_s8 <= lowf_s7;
			end else begin
				factor_s8 <= highf_w;
			end
		end
	end

	assign factor = factor_s8;

endmodule

### rtl/biquad_spline_correlation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_spline_correlation_core
// Spline correlation of two points: one factor lane per dimension, then a
// chain of multiply stages forming the product, rounded to Q1.16.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid, in_stall, point_a_*, point_b_*  request in, stall out
//  output    out_valid, out_stall, correlation         request out, stall in
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data write in, ready always high
//
//  one request per cycle while in_stall is low; the path runs through the eight
//  lane stages, one multiply stage per dimension and the output register.
//  reset clears the stage valid bits and loads active_dims 1, scales 1.0.
//  a stall holds the output register; stages behind it keep filling bubbles,
//  so requests are still taken until the pipe is full.
// ----------------------------------------------------------------------------
module biquad_spline_correlation_core #(
	parameter int MAX_DIMS   = bqsc_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS = bqsc_pkg::COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [COORD_BITS-1:0]                 point_a_0,
	input  logic [COORD_BITS-1:0]                 point_a_1,
	input  logic [COORD_BITS-1:0]                 point_a_2,
	input  logic [COORD_BITS-1:0]                 point_a_3,
	input  logic [COORD_BITS-1:0]                 point_a_4,
	input  logic [COORD_BITS-1:0]                 point_a_5,
	input  logic [COORD_BITS-1:0]                 point_b_0,
	input  logic [COORD_BITS-1:0]                 point_b_1,
	input  logic [COORD_BITS-1:0]                 point_b_2,
	input  logic [COORD_BITS-1:0]                 point_b_3,
	input  logic [COORD_BITS-1:0]                 point_b_4,
	input  logic [COORD_BITS-1:0]                 point_b_5,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [bqsc_pkg::OUT_BITS-1:0]         correlation,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bqsc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [bqsc_pkg::SCALE_BITS-1:0]       cfg_data
);

	localparam int LS   = bqsc_pkg::LANE_STAGES;
	localparam int NSTG = LS + MAX_DIMS + 1;
	localparam int FB   = bqsc_pkg::FAC_BITS;
	localparam int WF   = bqsc_pkg::WORK_FRAC;
	localparam int NP   = bqsc_pkg::NUM_PORTS;
	localparam int RND  = WF - bqsc_pkg::OUT_FRAC;

	logic [bqsc_pkg::DIMS_BITS-1:0]  active_dims_q;
	logic [bqsc_pkg::SCALE_BITS-1:0] scale_q [NP];
	logic [COORD_BITS-1:0]           pa [NP];
	logic [COORD_BITS-1:0]           pb [NP];
	logic [NSTG-1:0]                 vld_q;
	logic [NSTG-1:0]                 rdy;
	logic [FB-1:0]                   fac_w [MAX_DIMS];
	logic [FB-1:0]                   acc_s [MAX_DIMS];
	logic [FB-1:0]                   fac_s [MAX_DIMS][MAX_DIMS];
	logic [bqsc_pkg::OUT_BITS-1:0]   corr_q;
	logic [FB:0]                     rnd_w;
	logic [bqsc_pkg::OUT_BITS-1:0]   res_w;

	assign pa = '{point_a_0, point_a_1, point_a_2, point_a_3, point_a_4, point_a_5};
	assign pb = '{point_b_0, point_b_1, point_b_2, point_b_3, point_b_4, point_b_5};

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dims_q <= bqsc_pkg::DIMS_BITS'(1);
			for (int i = 0; i < NP; i++) begin
				scale_q[i] <= bqsc_pkg::SCALE_BITS'(1) << bqsc_pkg::SCALE_FRAC;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (bqsc_pkg::cfg_reg_t'(cfg_index))
				bqsc_pkg::REG_ACTIVE_DIMS: active_dims_q <= cfg_data[bqsc_pkg::DIMS_BITS-1:0];
				bqsc_pkg::REG_SCALE_0:     scale_q[0] <= cfg_data;
				bqsc_pkg::REG_SCALE_1:     scale_q[1] <= cfg_data;
				bqsc_pkg::REG_SCALE_2:     scale_q[2] <= cfg_data;
				bqsc_pkg::REG_SCALE_3:     scale_q[3] <= cfg_data;
				bqsc_pkg::REG_SCALE_4:     scale_q[4] <= cfg_data;
				bqsc_pkg::REG_SCALE_5:     scale_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the stage after it moves on
	always_comb begin
		rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
		for (int i = NSTG - 2; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign in_stall = !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// one factor lane per dimension
	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_lane
		bqsc_factor #(
			.COORD_BITS(COORD_BITS)
		) u_factor (
			.clk    (clk),
			.adv    (rdy[LS-1:0]),
			.a      (pa[k]),
			.b      (pb[k]),
			.scale  (scale_q[k]),
			.active (32'(k) < 32'(active_dims_q)),
			.factor (fac_w[k])
		);
	end

	// product chain, one multiply stage per dimension; factors ride along
	for (genvar j = 0; j < MAX_DIMS; j++) begin : g_mul
		logic [FB-1:0]   acc_in;
		logic [FB-1:0]   fac_in [MAX_DIMS];
		logic [2*FB-1:0] prd;

		if (j == 0) begin : g_first
			assign acc_in = bqsc_pkg::ONE_W;
			assign fac_in = fac_w;
		end else begin : g_next
			assign acc_in = acc_s[j-1];
			assign fac_in = fac_s[j-1];
		end

		assign prd = acc_in * fac_in[j];

		always_ff @(posedge clk) begin
			if (rdy[LS+j]) begin
				acc_s[j] <= prd[WF+FB-1:WF];
				fac_s[j] <= fac_in;
			end
		end
	end

	// round half up to Q1.16
	assign rnd_w = (FB+1)'(acc_s[MAX_DIMS-1]) + ((FB+1)'(1) << (RND - 1));
	assign res_w = ((rnd_w >> RND) > (FB+1)'(bqsc_pkg::OUT_ONE)) ? bqsc_pkg::OUT_ONE
		: bqsc_pkg::OUT_BITS'(rnd_w >> RND);

	always_ff @(posedge clk) begin
		if (rdy[NSTG-1]) begin
			corr_q <= res_w;
		end
	end

	assign out_valid   = vld_q[NSTG-1];
	assign correlation = corr_q;

	ap_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> correlation <= bqsc_pkg::OUT_ONE)
		else $error("correlation above 1.0");

	ap_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_q[0])
		else $error("input stalled while first stage empty");

	ap_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted request not in first stage");

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-1] && out_stall) |=> (vld_q[NSTG-1] && $stable(corr_q)))
		else $error("stalled result lost");

endmodule
